// File: rtl/core/sht_pkg.sv
// Package for the scheduled hysteresis thermostat core.
// Holds shared constants, register and mode codes, the controller state type
// and the command/status structs. No dependencies.
package sht_pkg;

    localparam int SLOTS_PER_DAY_DEF = 4;
    localparam int PREHEAT_CAP_DEF   = 3600;
    localparam int DAYS              = 7;
    localparam int TOD_W             = 17;
    localparam int TEMP_W            = 16;
    localparam int CFG_AW            = 5;
    localparam int CFG_DW            = 32;

    localparam logic [1:0] RUN_OFF     = 2'd0;
    localparam logic [1:0] RUN_ECO     = 2'd1;
    localparam logic [1:0] RUN_COMFORT = 2'd2;
    localparam logic [1:0] RUN_PROGRAM = 2'd3;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_LOW_SETP  = 3'd1;
    localparam logic [2:0] REG_HIGH_SETP = 3'd2;
    localparam logic [2:0] REG_HYST      = 3'd3;
    localparam logic [2:0] REG_MIN_ON    = 3'd4;
    localparam logic [2:0] REG_MIN_OFF   = 3'd5;
    localparam logic [2:0] REG_HEAT_RESP = 3'd6;
    localparam logic [2:0] REG_GAIN      = 3'd7;

    localparam logic [14:0] HYST_RST      = 15'd30;
    localparam logic [16:0] HEAT_RESP_RST = 17'd1800;
    localparam logic [15:0] GAIN_RST      = 16'd36571;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] low_setpoint;
        logic [15:0] high_setpoint;
        logic [14:0] hysteresis;
        logic [31:0] min_on_ms;
        logic [31:0] min_off_ms;
        logic [16:0] heat_response;
        logic [15:0] preheat_gain;
    } sht_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_SEL,
        ST_REG,
        ST_DONE
    } sht_state_t;

    typedef struct packed {
        logic start;
        logic mem_wr;
        logic scan_rd;
        logic sel;
        logic reg_upd;
        logic out_load;
    } sht_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic item_write;
        logic prog_mode;
        logic out_ready;
    } sht_status_t;

endpackage

// File: rtl/core/sht_item_if.sv
// Input channel of the thermostat core: valid/ready plus the item fields.
// No dependencies.
interface sht_item_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] temperature_now;
    logic [31:0]        now_ms;
    logic [16:0]        time_of_day;
    logic [2:0]         day_of_week;
    logic [1:0]         slot_index;
    logic [16:0]        slot_start;
    logic [16:0]        slot_end;
    logic               slot_valid;

    modport source (
        output valid, command, temperature_now, now_ms, time_of_day, day_of_week,
               slot_index, slot_start, slot_end, slot_valid,
        input  ready
    );
    modport sink (
        input  valid, command, temperature_now, now_ms, time_of_day, day_of_week,
               slot_index, slot_start, slot_end, slot_valid,
        output ready
    );
endinterface

// File: rtl/core/sht_result_if.sv
// Output channel of the thermostat core: valid/ready plus the result fields.
// No dependencies.
interface sht_result_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic comfort_selected;

    modport source (
        output valid, heater_on, comfort_selected,
        input  ready
    );
    modport sink (
        input  valid, heater_on, comfort_selected,
        output ready
    );
endinterface

// File: rtl/core/sht_regs.sv
// APB-style configuration register file of the thermostat core.
// Depends on sht_pkg.
module sht_regs
    import sht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output sht_cfg_t          cfg
);

    sht_cfg_t   cfg_reg;
    sht_cfg_t   cfg_next;
    logic [2:0] reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_MODE:      cfg_next.mode          = pwdata[1:0];
                REG_LOW_SETP:  cfg_next.low_setpoint  = pwdata[15:0];
                REG_HIGH_SETP: cfg_next.high_setpoint = pwdata[15:0];
                REG_HYST:      cfg_next.hysteresis    = pwdata[14:0];
                REG_MIN_ON:    cfg_next.min_on_ms     = pwdata;
                REG_MIN_OFF:   cfg_next.min_off_ms    = pwdata;
                REG_HEAT_RESP: cfg_next.heat_response = pwdata[16:0];
                REG_GAIN:      cfg_next.preheat_gain  = pwdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE:      prdata = {30'd0, cfg_reg.mode};
            REG_LOW_SETP:  prdata = {{16{cfg_reg.low_setpoint[15]}}, cfg_reg.low_setpoint};
            REG_HIGH_SETP: prdata = {{16{cfg_reg.high_setpoint[15]}}, cfg_reg.high_setpoint};
            REG_HYST:      prdata = {17'd0, cfg_reg.hysteresis};
            REG_MIN_ON:    prdata = cfg_reg.min_on_ms;
            REG_MIN_OFF:   prdata = cfg_reg.min_off_ms;
            REG_HEAT_RESP: prdata = {15'd0, cfg_reg.heat_response};
            REG_GAIN:      prdata = {16'd0, cfg_reg.preheat_gain};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= RUN_OFF;
            cfg_reg.low_setpoint  <= '0;
            cfg_reg.high_setpoint <= '0;
            cfg_reg.hysteresis    <= HYST_RST;
            cfg_reg.min_on_ms     <= '0;
            cfg_reg.min_off_ms    <= '0;
            cfg_reg.heat_response <= HEAT_RESP_RST;
            cfg_reg.preheat_gain  <= GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/sht_ctrl.sv
// Controller state machine of the thermostat core: sequences slot writes,
// the slot scan, comfort selection, regulation and the output register.
// Depends on sht_pkg.
module sht_ctrl
    import sht_pkg::*;
#(
    parameter int SLOTS_PER_DAY = SLOTS_PER_DAY_DEF,
    localparam int IW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  sht_status_t   status,
    output sht_cmd_t      cmd,
    output logic [IW-1:0] scan_idx,
    output logic          item_ready,
    output logic          result_valid
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS_PER_DAY - 1);

    sht_state_t    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free     = !out_valid_reg || status.out_ready;
    assign scan_idx     = idx_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.item_valid)
                begin
                    if (status.item_write)
                        state_next = ST_WRITE;
                    else if (status.prog_mode)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_REG;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_SEL;
            ST_SEL:   state_next = ST_REG;
            ST_REG:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.start  = status.item_valid;
                idx_next   = '0;
            end
            ST_WRITE: cmd.mem_wr = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                idx_next    = idx_reg + 1'b1;
            end
            ST_DRAIN: cmd = '0;
            ST_SEL:   cmd.sel = 1'b1;
            ST_REG:   cmd.reg_upd = 1'b1;
            ST_DONE:  cmd.out_load = out_free;
            default:  cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/sht_dp.sv
// Datapath of the thermostat core: item capture, slot memory with valid bits,
// slot scan, preheat lead pipeline, regulation and the result register.
// Depends on sht_pkg.
module sht_dp
    import sht_pkg::*;
#(
    parameter int SLOTS_PER_DAY = SLOTS_PER_DAY_DEF,
    parameter int PREHEAT_CAP   = PREHEAT_CAP_DEF,
    localparam int IW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sht_cfg_t           cfg,
    input  sht_cmd_t           cmd,
    input  logic [IW-1:0]      scan_idx,
    input  logic signed [15:0] temperature_now,
    input  logic [31:0]        now_ms,
    input  logic [16:0]        time_of_day,
    input  logic [2:0]         day_of_week,
    input  logic [1:0]         slot_index,
    input  logic [16:0]        slot_start,
    input  logic [16:0]        slot_end,
    input  logic               slot_valid,
    output logic               heater_on,
    output logic               comfort_selected
);

    localparam int DEPTH = DAYS * SLOTS_PER_DAY;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [34:0] CAP_SCALED = 35'(PREHEAT_CAP * 256);
    localparam logic [16:0]        CAP_LEAD   = 17'(PREHEAT_CAP);

    // captured item
    logic signed [15:0] temp_reg;
    logic [31:0]        now_reg;
    logic [16:0]        tod_reg;
    logic [2:0]         day_reg;
    logic [1:0]         sidx_reg;
    logic [16:0]        sstart_reg, send_reg;
    logic               svalid_reg;

    // slot storage
    logic [33:0]      slot_mem [DEPTH];
    logic [DEPTH-1:0] slot_vld_reg;
    logic             row_ok, wr_ok;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [16:0]      rd_start_reg, rd_end_reg;
    logic             rd_valid_reg;
    logic             eval_reg;

    // scan results
    logic        active_reg, found_reg;
    logic [16:0] best_reg;
    logic [16:0] start_gap;

    // preheat lead pipeline
    logic signed [16:0] deficit;
    logic signed [33:0] prod_reg;
    logic signed [34:0] raw;
    logic [16:0]        lead_reg;

    // heater state
    logic        heater_reg;
    logic [31:0] last_on_reg, last_off_reg;
    logic        comfort_reg;
    logic        out_heater_reg, out_comfort_reg;

    // regulation
    logic               use_high;
    logic signed [15:0] setp;
    logic signed [16:0] thr;
    logic               temp_lt, temp_gt;
    logic [31:0]        el_on, el_off;

    assign row_ok  = (day_reg < 3'(DAYS));
    assign wr_ok   = row_ok && (int'(sidx_reg) < SLOTS_PER_DAY);
    assign wr_addr = wr_ok ? AW'(int'(day_reg) * SLOTS_PER_DAY + int'(sidx_reg)) : '0;
    assign rd_addr = row_ok ? AW'(int'(day_reg) * SLOTS_PER_DAY + int'(scan_idx)) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            temp_reg   <= temperature_now;
            now_reg    <= now_ms;
            tod_reg    <= time_of_day;
            day_reg    <= day_of_week;
            sidx_reg   <= slot_index;
            sstart_reg <= slot_start;
            send_reg   <= slot_end;
            svalid_reg <= slot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_ok)
            slot_mem[wr_addr] <= {sstart_reg, send_reg};
        {rd_start_reg, rd_end_reg} <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            rd_valid_reg <= 1'b0;
            eval_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.mem_wr && wr_ok)
                slot_vld_reg[wr_addr] <= svalid_reg;
            rd_valid_reg <= row_ok && slot_vld_reg[rd_addr];
            eval_reg     <= cmd.scan_rd;
        end
    end

    // evaluate each slot in the cycle after its read
    assign start_gap = rd_start_reg - tod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            active_reg <= 1'b0;
            found_reg  <= 1'b0;
            best_reg   <= '0;
        end
        else if (eval_reg && rd_valid_reg)
        begin
            if (tod_reg >= rd_start_reg && tod_reg <= rd_end_reg)
                active_reg <= 1'b1;
            if (!found_reg || start_gap < best_reg)
            begin
                best_reg  <= start_gap;
                found_reg <= 1'b1;
            end
        end
    end

    // free-running from the captured item; the product is registered in prod_reg, then the clamped lead in lead_reg
    assign deficit = $signed({cfg.high_setpoint[15], cfg.high_setpoint})
                   - $signed({temp_reg[15], temp_reg});
    assign raw     = $signed({10'd0, cfg.heat_response, 8'd0})
                   - $signed({prod_reg[33], prod_reg});

    always_ff @(posedge clk)
    begin
        prod_reg <= 34'(deficit * $signed({1'b0, cfg.preheat_gain}));
        if (raw < 0 || raw > CAP_SCALED)
            lead_reg <= CAP_LEAD;
        else
            lead_reg <= raw[24:8];
    end

    assign use_high = (cfg.mode == RUN_COMFORT) || ((cfg.mode == RUN_PROGRAM) && comfort_reg);
    assign setp     = use_high ? $signed(cfg.high_setpoint) : $signed(cfg.low_setpoint);
    assign thr      = $signed({setp[15], setp}) - $signed({2'b00, cfg.hysteresis});
    assign temp_lt  = $signed({temp_reg[15], temp_reg}) < thr;
    assign temp_gt  = temp_reg > setp;
    assign el_on    = now_reg - last_on_reg;
    assign el_off   = now_reg - last_off_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            comfort_reg <= 1'b0;
        else if (cmd.sel)
            comfort_reg <= active_reg || (found_reg && best_reg <= lead_reg);
        else if (cmd.reg_upd)
            comfort_reg <= use_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg   <= 1'b0;
            last_on_reg  <= '0;
            last_off_reg <= '0;
        end
        else if (cmd.reg_upd)
        begin
            if (cfg.mode == RUN_OFF)
            begin
                if (heater_reg)
                begin
                    heater_reg   <= 1'b0;
                    last_off_reg <= now_reg;
                end
            end
            else if (!heater_reg)
            begin
                if (temp_lt && el_off > cfg.min_off_ms)
                begin
                    heater_reg  <= 1'b1;
                    last_on_reg <= now_reg;
                end
            end
            else if (temp_gt && el_on > cfg.min_on_ms)
            begin
                heater_reg   <= 1'b0;
                last_off_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_heater_reg  <= heater_reg;
            out_comfort_reg <= comfort_reg;
        end
    end

    assign heater_on        = out_heater_reg;
    assign comfort_selected = out_comfort_reg;

endmodule

// File: rtl/core/scheduled_hysteresis_thermostat_core.sv
// Top level of the scheduled hysteresis thermostat core.
// Depends on sht_pkg, sht_item_if, sht_result_if, sht_regs, sht_ctrl, sht_dp.
//
//   port        kind         word / transfer
//   ----------  -----------  ------------------------------------------------
//   item        valid/ready  check or slot write: command, temperature, time
//   result      valid/ready  heater_on, comfort_selected, one per item
//   APB         psel/penable configuration registers at byte address 4*i
//
// Slot write: ST_WRITE, ST_DONE. Check in modes off/low/high: ST_REG, ST_DONE.
// Program check: a one-slot-a-cycle scan of the day's row through the slot
// memory read port, then ST_DRAIN, ST_SEL, ST_REG, ST_DONE. One item is in
// flight at a time; a finished word waits in the result register while the
// next item is taken. rst_n clears control, heater state, all slot valid bits.
module scheduled_hysteresis_thermostat_core
    import sht_pkg::*;
#(
    parameter int SLOTS_PER_DAY = SLOTS_PER_DAY_DEF,
    parameter int PREHEAT_CAP   = PREHEAT_CAP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    sht_item_if.sink          item,
    sht_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int IW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;

    sht_cfg_t      cfg;
    sht_cmd_t      cmd;
    sht_status_t   status;
    logic [IW-1:0] scan_idx;
    logic          item_ready;
    logic          result_valid;

    assign status.item_valid = item.valid;
    assign status.item_write = item.command;
    assign status.prog_mode  = (cfg.mode == RUN_PROGRAM);
    assign status.out_ready  = result.ready;

    assign item.ready   = item_ready;
    assign result.valid = result_valid;

    sht_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sht_ctrl #(
        .SLOTS_PER_DAY (SLOTS_PER_DAY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .cmd          (cmd),
        .scan_idx     (scan_idx),
        .item_ready   (item_ready),
        .result_valid (result_valid)
    );

    sht_dp #(
        .SLOTS_PER_DAY (SLOTS_PER_DAY),
        .PREHEAT_CAP   (PREHEAT_CAP)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .scan_idx         (scan_idx),
        .temperature_now  (item.temperature_now),
        .now_ms           (item.now_ms),
        .time_of_day      (item.time_of_day),
        .day_of_week      (item.day_of_week),
        .slot_index       (item.slot_index),
        .slot_start       (item.slot_start),
        .slot_end         (item.slot_end),
        .slot_valid       (item.slot_valid),
        .heater_on        (result.heater_on),
        .comfort_selected (result.comfort_selected)
    );

endmodule
